// File: hdl/ops_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ops_pkg
// Shared constants for the orbit point step datapath.
// ----------------------------------------------------------------------------
package ops_pkg;

    localparam int STEP_BITS = 12;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 12'd500;
    localparam int OUT_BITS = 17;

    typedef logic [STEP_BITS-1:0] t_step;

endpackage

// File: hdl/ops_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ops_sqrt_cell
// One root bit of a pipelined floor square root; hands state to the next cell.
// ----------------------------------------------------------------------------
module ops_sqrt_cell #(
    parameter int RW  = 16,
    parameter int SBW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [2*RW-1:0] i_rad,
    input  logic [RW+1:0]   i_rem,
    input  logic [RW-1:0]   i_root,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_vld,
    output logic [2*RW-1:0] o_rad,
    output logic [RW+1:0]   o_rem,
    output logic [RW-1:0]   o_root,
    output logic [SBW-1:0]  o_sb
);

    logic            r_vld;
    logic [2*RW-1:0] r_rad, n_rad;
    logic [RW+1:0]   r_rem, n_rem;
    logic [RW-1:0]   r_root, n_root;
    logic [SBW-1:0]  r_sb;
    logic [RW+3:0]   w_cat;
    logic [RW+3:0]   w_trial;

    always_comb begin
        // bring down the next two radicand bits, test root*4+1
        w_cat   = {i_rem, i_rad[2*RW-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        n_rad   = {i_rad[2*RW-3:0], 2'b00};
        if (w_cat >= w_trial) begin
            n_rem  = (RW+2)'(w_cat - w_trial);
            n_root = {i_root[RW-2:0], 1'b1};
        end else begin
            n_rem  = w_cat[RW+1:0];
            n_root = {i_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_sb   <= i_sb;
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_sb   = r_sb;

endmodule

// File: hdl/ops_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ops_div_cell
// One quotient bit of two restoring divisions sharing one divisor.
// ----------------------------------------------------------------------------
module ops_div_cell #(
    parameter int NW  = 28,
    parameter int DW  = 16,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  logic [DW-1:0]  i_den,
    input  logic [NW-1:0]  i_num_a,
    input  logic [DW-1:0]  i_rem_a,
    input  logic [NW-1:0]  i_num_b,
    input  logic [DW-1:0]  i_rem_b,
    input  logic [SBW-1:0] i_sb,
    output logic           o_vld,
    output logic [DW-1:0]  o_den,
    output logic [NW-1:0]  o_num_a,
    output logic [DW-1:0]  o_rem_a,
    output logic [NW-1:0]  o_num_b,
    output logic [DW-1:0]  o_rem_b,
    output logic [SBW-1:0] o_sb
);

    logic           r_vld;
    logic [DW-1:0]  r_den;
    logic [NW-1:0]  r_num_a, n_num_a, r_num_b, n_num_b;
    logic [DW-1:0]  r_rem_a, n_rem_a, r_rem_b, n_rem_b;
    logic [SBW-1:0] r_sb;
    logic [DW:0]    w_cat_a, w_cat_b;
    logic           w_ge_a, w_ge_b;

    always_comb begin
        // shift in the next dividend bit, subtract when it fits
        w_cat_a = {i_rem_a, i_num_a[NW-1]};
        w_cat_b = {i_rem_b, i_num_b[NW-1]};
        w_ge_a  = w_cat_a >= {1'b0, i_den};
        w_ge_b  = w_cat_b >= {1'b0, i_den};
        n_rem_a = w_ge_a ? DW'(w_cat_a - {1'b0, i_den}) : w_cat_a[DW-1:0];
        n_rem_b = w_ge_b ? DW'(w_cat_b - {1'b0, i_den}) : w_cat_b[DW-1:0];
        n_num_a = {i_num_a[NW-2:0], w_ge_a};
        n_num_b = {i_num_b[NW-2:0], w_ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den   <= i_den;
        r_num_a <= n_num_a;
        r_rem_a <= n_rem_a;
        r_num_b <= n_num_b;
        r_rem_b <= n_rem_b;
        r_sb    <= i_sb;
    end

    assign o_vld   = r_vld;
    assign o_den   = r_den;
    assign o_num_a = r_num_a;
    assign o_rem_a = r_rem_a;
    assign o_num_b = r_num_b;
    assign o_rem_b = r_rem_b;
    assign o_sb    = r_sb;

endmodule

// File: hdl/orbit_point_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_point_step
// Next waypoint on a circle about a centre, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the mover and centre fields and raise start; the
//   transaction is taken at any edge where start is high and busy is low.
//   busy never rises, so a new transaction may enter every cycle.
//   Result channel: o_strobe marks one cycle holding next_x/y/z and
//   o_point_valid. The receiver cannot stall; results stream out in order.
//   Configuration: one write channel (i_cfg_valid / o_cfg_ready, always
//   ready) sets the step distance. Write it only while no transaction is
//   in flight.
//   The pipeline depth is set by the length of the cell rows: one cell per root
//   bit in each square root, one cell per quotient bit in each divider.
//   Throughput: one transaction per cycle.
//   Reset: empties the pipeline (no strobes in flight) and sets the step
//   distance to 500.
// ----------------------------------------------------------------------------
module orbit_point_step
    import ops_pkg::*;
#(
    parameter int COORD_BITS = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [COORD_BITS-1:0] i_self_x,
    input  logic signed [COORD_BITS-1:0] i_self_y,
    input  logic signed [COORD_BITS-1:0] i_self_z,
    input  logic signed [COORD_BITS-1:0] i_centre_x,
    input  logic signed [COORD_BITS-1:0] i_centre_y,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [STEP_BITS-1:0]       i_cfg_data,
    output logic                       o_strobe,
    output logic signed [OUT_BITS-1:0] o_next_x,
    output logic signed [OUT_BITS-1:0] o_next_y,
    output logic signed [COORD_BITS-1:0] o_next_z,
    output logic                       o_point_valid
);

    localparam int CB   = COORD_BITS;
    localparam int RW1  = CB + 1;                       // offset and radius width
    localparam int NW1  = RW1 + STEP_BITS;              // |offset| * step
    localparam int NXW  = ((RW1 > STEP_BITS + 1) ? RW1 : STEP_BITS + 1) + 1;
    localparam int RW2  = NXW;                          // new length width
    localparam int NW2  = NXW + RW1;                    // |new offset| * radius
    localparam int SW   = ((CB + 3) > (OUT_BITS + 1)) ? (CB + 3) : (OUT_BITS + 1);
    localparam int SB1  = 2 * RW1 + 3 * CB;             // dx, dy, z, cx, cy
    localparam int SBD1 = 2 * RW1 + 3 * CB + 3;         // + r zero, signs
    localparam int SB2  = 2 * NXW + 3 * CB + RW1 + 1;   // nx, ny, z, cx, cy, r, bad
    localparam int SBD2 = 3 * CB + 3;                   // z, cx, cy, bad, signs

    // ---------------- configuration ----------------
    t_step r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_valid) begin
            r_step <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // ---------------- stage A: offset from centre ----------------
    logic                 r_a_vld;
    logic signed [RW1-1:0] r_a_dx, r_a_dy;
    logic signed [CB-1:0]  r_a_z, r_a_cx, r_a_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_dx <= RW1'(i_self_x) - RW1'(i_centre_x);
        r_a_dy <= RW1'(i_self_y) - RW1'(i_centre_y);
        r_a_z  <= i_self_z;
        r_a_cx <= i_centre_x;
        r_a_cy <= i_centre_y;
    end

    // ---------------- stage B: squared radius ----------------
    logic signed [2*RW1-1:0] w_sqx, w_sqy;
    logic                    r_b_vld;
    logic [2*RW1-1:0]        r_b_sum;
    logic [SB1-1:0]          r_b_sb;

    assign w_sqx = r_a_dx * r_a_dx;
    assign w_sqy = r_a_dy * r_a_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sum <= $unsigned(w_sqx + w_sqy);
        r_b_sb  <= {r_a_dx, r_a_dy, r_a_z, r_a_cx, r_a_cy};
    end

    // ---------------- root row 1: radius ----------------
    logic             s1_vld  [0:RW1];
    logic [2*RW1-1:0] s1_rad  [0:RW1];
    logic [RW1+1:0]   s1_rem  [0:RW1];
    logic [RW1-1:0]   s1_root [0:RW1];
    logic [SB1-1:0]   s1_sb   [0:RW1];

    assign s1_vld[0]  = r_b_vld;
    assign s1_rad[0]  = r_b_sum;
    assign s1_rem[0]  = '0;
    assign s1_root[0] = '0;
    assign s1_sb[0]   = r_b_sb;

    for (genvar g = 0; g < RW1; g++) begin : g_sqrt1
        ops_sqrt_cell #(.RW(RW1), .SBW(SB1)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (s1_vld[g]),
            .i_rad  (s1_rad[g]),
            .i_rem  (s1_rem[g]),
            .i_root (s1_root[g]),
            .i_sb   (s1_sb[g]),
            .o_vld  (s1_vld[g+1]),
            .o_rad  (s1_rad[g+1]),
            .o_rem  (s1_rem[g+1]),
            .o_root (s1_root[g+1]),
            .o_sb   (s1_sb[g+1])
        );
    end

    // ---------------- stage C: perpendicular step numerators ----------------
    logic signed [RW1-1:0] w_c_dx, w_c_dy;
    logic signed [CB-1:0]  w_c_z, w_c_cx, w_c_cy;
    logic [RW1-1:0]        w_c_adx, w_c_ady;
    logic                  r_c_vld;
    logic [RW1-1:0]        r_c_r;
    logic [NW1-1:0]        r_c_numx, r_c_numy;
    logic [SBD1-1:0]       r_c_sb;

    assign {w_c_dx, w_c_dy, w_c_z, w_c_cx, w_c_cy} = s1_sb[RW1];
    assign w_c_adx = w_c_dx[RW1-1] ? RW1'(-w_c_dx) : w_c_dx;
    assign w_c_ady = w_c_dy[RW1-1] ? RW1'(-w_c_dy) : w_c_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= s1_vld[RW1];
        end
    end

    // ox = -dy*d/r is negative when dy > 0; oy = dx*d/r negative when dx < 0
    always_ff @(posedge i_clk) begin
        r_c_r    <= s1_root[RW1];
        r_c_numx <= NW1'(w_c_ady * r_step);
        r_c_numy <= NW1'(w_c_adx * r_step);
        r_c_sb   <= {w_c_dx, w_c_dy, w_c_z, w_c_cx, w_c_cy,
                     (s1_root[RW1] == '0),
                     (!w_c_dy[RW1-1] && (w_c_dy != '0)),
                     w_c_dx[RW1-1]};
    end

    // ---------------- divider row 1: step offsets ----------------
    logic            d1_vld [0:NW1];
    logic [RW1-1:0]  d1_den [0:NW1];
    logic [NW1-1:0]  d1_nx  [0:NW1];
    logic [RW1-1:0]  d1_rx  [0:NW1];
    logic [NW1-1:0]  d1_ny  [0:NW1];
    logic [RW1-1:0]  d1_ry  [0:NW1];
    logic [SBD1-1:0] d1_sb  [0:NW1];

    assign d1_vld[0] = r_c_vld;
    assign d1_den[0] = r_c_r;
    assign d1_nx[0]  = r_c_numx;
    assign d1_rx[0]  = '0;
    assign d1_ny[0]  = r_c_numy;
    assign d1_ry[0]  = '0;
    assign d1_sb[0]  = r_c_sb;

    for (genvar g = 0; g < NW1; g++) begin : g_div1
        ops_div_cell #(.NW(NW1), .DW(RW1), .SBW(SBD1)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (d1_vld[g]),
            .i_den  (d1_den[g]),
            .i_num_a(d1_nx[g]),
            .i_rem_a(d1_rx[g]),
            .i_num_b(d1_ny[g]),
            .i_rem_b(d1_ry[g]),
            .i_sb   (d1_sb[g]),
            .o_vld  (d1_vld[g+1]),
            .o_den  (d1_den[g+1]),
            .o_num_a(d1_nx[g+1]),
            .o_rem_a(d1_rx[g+1]),
            .o_num_b(d1_ny[g+1]),
            .o_rem_b(d1_ry[g+1]),
            .o_sb   (d1_sb[g+1])
        );
    end

    // ---------------- stage D: new offset ----------------
    logic signed [RW1-1:0] w_d_dx, w_d_dy;
    logic signed [CB-1:0]  w_d_z, w_d_cx, w_d_cy;
    logic                  w_d_rzero, w_d_negx, w_d_negy;
    logic signed [NXW-1:0] w_d_ox, w_d_oy;
    logic                  r_d_vld;
    logic signed [NXW-1:0] r_d_nx, r_d_ny;
    logic [RW1-1:0]        r_d_r;
    logic signed [CB-1:0]  r_d_z, r_d_cx, r_d_cy;
    logic                  r_d_rzero;

    assign {w_d_dx, w_d_dy, w_d_z, w_d_cx, w_d_cy, w_d_rzero, w_d_negx, w_d_negy} =
        d1_sb[NW1];
    // step offsets never exceed the step distance, so the low bits hold them
    assign w_d_ox = w_d_negx ? -NXW'({1'b0, d1_nx[NW1][STEP_BITS-1:0]})
                             :  NXW'({1'b0, d1_nx[NW1][STEP_BITS-1:0]});
    assign w_d_oy = w_d_negy ? -NXW'({1'b0, d1_ny[NW1][STEP_BITS-1:0]})
                             :  NXW'({1'b0, d1_ny[NW1][STEP_BITS-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= d1_vld[NW1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_nx    <= NXW'(w_d_dx) + w_d_ox;
        r_d_ny    <= NXW'(w_d_dy) + w_d_oy;
        r_d_r     <= d1_den[NW1];
        r_d_z     <= w_d_z;
        r_d_cx    <= w_d_cx;
        r_d_cy    <= w_d_cy;
        r_d_rzero <= w_d_rzero;
    end

    // ---------------- stage E: squared new length ----------------
    logic signed [2*NXW-1:0] w_nsqx, w_nsqy;
    logic                    r_e_vld;
    logic [2*NXW-1:0]        r_e_sum;
    logic [SB2-1:0]          r_e_sb;

    assign w_nsqx = r_d_nx * r_d_nx;
    assign w_nsqy = r_d_ny * r_d_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_sum <= $unsigned(w_nsqx + w_nsqy);
        r_e_sb  <= {r_d_nx, r_d_ny, r_d_z, r_d_cx, r_d_cy, r_d_r, r_d_rzero};
    end

    // ---------------- root row 2: new length ----------------
    logic             s2_vld  [0:RW2];
    logic [2*RW2-1:0] s2_rad  [0:RW2];
    logic [RW2+1:0]   s2_rem  [0:RW2];
    logic [RW2-1:0]   s2_root [0:RW2];
    logic [SB2-1:0]   s2_sb   [0:RW2];

    assign s2_vld[0]  = r_e_vld;
    assign s2_rad[0]  = r_e_sum;
    assign s2_rem[0]  = '0;
    assign s2_root[0] = '0;
    assign s2_sb[0]   = r_e_sb;

    for (genvar g = 0; g < RW2; g++) begin : g_sqrt2
        ops_sqrt_cell #(.RW(RW2), .SBW(SB2)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (s2_vld[g]),
            .i_rad  (s2_rad[g]),
            .i_rem  (s2_rem[g]),
            .i_root (s2_root[g]),
            .i_sb   (s2_sb[g]),
            .o_vld  (s2_vld[g+1]),
            .o_rad  (s2_rad[g+1]),
            .o_rem  (s2_rem[g+1]),
            .o_root (s2_root[g+1]),
            .o_sb   (s2_sb[g+1])
        );
    end

    // ---------------- stage F: rescale numerators ----------------
    logic signed [NXW-1:0] w_f_nx, w_f_ny;
    logic signed [CB-1:0]  w_f_z, w_f_cx, w_f_cy;
    logic [RW1-1:0]        w_f_r;
    logic                  w_f_rzero;
    logic [NXW-1:0]        w_f_anx, w_f_any;
    logic                  r_f_vld;
    logic [RW2-1:0]        r_f_n;
    logic [NW2-1:0]        r_f_numx, r_f_numy;
    logic [SBD2-1:0]       r_f_sb;

    assign {w_f_nx, w_f_ny, w_f_z, w_f_cx, w_f_cy, w_f_r, w_f_rzero} = s2_sb[RW2];
    assign w_f_anx = w_f_nx[NXW-1] ? NXW'(-w_f_nx) : w_f_nx;
    assign w_f_any = w_f_ny[NXW-1] ? NXW'(-w_f_ny) : w_f_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= s2_vld[RW2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_n    <= s2_root[RW2];
        r_f_numx <= NW2'(w_f_anx * w_f_r);
        r_f_numy <= NW2'(w_f_any * w_f_r);
        r_f_sb   <= {w_f_z, w_f_cx, w_f_cy,
                     (w_f_rzero || (s2_root[RW2] == '0)),
                     w_f_nx[NXW-1], w_f_ny[NXW-1]};
    end

    // ---------------- divider row 2: point on the circle ----------------
    logic            d2_vld [0:NW2];
    logic [RW2-1:0]  d2_den [0:NW2];
    logic [NW2-1:0]  d2_nx  [0:NW2];
    logic [RW2-1:0]  d2_rx  [0:NW2];
    logic [NW2-1:0]  d2_ny  [0:NW2];
    logic [RW2-1:0]  d2_ry  [0:NW2];
    logic [SBD2-1:0] d2_sb  [0:NW2];

    assign d2_vld[0] = r_f_vld;
    assign d2_den[0] = r_f_n;
    assign d2_nx[0]  = r_f_numx;
    assign d2_rx[0]  = '0;
    assign d2_ny[0]  = r_f_numy;
    assign d2_ry[0]  = '0;
    assign d2_sb[0]  = r_f_sb;

    for (genvar g = 0; g < NW2; g++) begin : g_div2
        ops_div_cell #(.NW(NW2), .DW(RW2), .SBW(SBD2)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (d2_vld[g]),
            .i_den  (d2_den[g]),
            .i_num_a(d2_nx[g]),
            .i_rem_a(d2_rx[g]),
            .i_num_b(d2_ny[g]),
            .i_rem_b(d2_ry[g]),
            .i_sb   (d2_sb[g]),
            .o_vld  (d2_vld[g+1]),
            .o_den  (d2_den[g+1]),
            .o_num_a(d2_nx[g+1]),
            .o_rem_a(d2_rx[g+1]),
            .o_num_b(d2_ny[g+1]),
            .o_rem_b(d2_ry[g+1]),
            .o_sb   (d2_sb[g+1])
        );
    end

    // ---------------- stage G: add centre, saturate, drive result ----------------
    localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (OUT_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [CB-1:0] w_g_z, w_g_cx, w_g_cy;
    logic                 w_g_bad, w_g_negx, w_g_negy;
    logic signed [SW-1:0] w_g_qx, w_g_qy, w_g_sx, w_g_sy, w_g_tx, w_g_ty;

    assign {w_g_z, w_g_cx, w_g_cy, w_g_bad, w_g_negx, w_g_negy} = d2_sb[NW2];

    // quotients are bounded by the radius, so RW1 low bits carry them
    assign w_g_qx = SW'({1'b0, d2_nx[NW2][RW1-1:0]});
    assign w_g_qy = SW'({1'b0, d2_ny[NW2][RW1-1:0]});
    assign w_g_sx = SW'(w_g_cx) + (w_g_negx ? -w_g_qx : w_g_qx);
    assign w_g_sy = SW'(w_g_cy) + (w_g_negy ? -w_g_qy : w_g_qy);
    assign w_g_tx = (w_g_sx > SAT_HI) ? SAT_HI : ((w_g_sx < SAT_LO) ? SAT_LO : w_g_sx);
    assign w_g_ty = (w_g_sy > SAT_HI) ? SAT_HI : ((w_g_sy < SAT_LO) ? SAT_LO : w_g_sy);

    logic                        r_g_vld;
    logic signed [OUT_BITS-1:0]  r_g_x, r_g_y;
    logic signed [CB-1:0]        r_g_z;
    logic                        r_g_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= d2_vld[NW2];
        end
    end

    // drop the point to zero when radius or new length was zero
    always_ff @(posedge i_clk) begin
        r_g_x  <= w_g_bad ? '0 : w_g_tx[OUT_BITS-1:0];
        r_g_y  <= w_g_bad ? '0 : w_g_ty[OUT_BITS-1:0];
        r_g_z  <= w_g_z;
        r_g_pv <= !w_g_bad;
    end

    assign o_strobe      = r_g_vld;
    assign o_next_x      = r_g_x;
    assign o_next_y      = r_g_y;
    assign o_next_z      = r_g_z;
    assign o_point_valid = r_g_pv;

endmodule

// File: tb/orbit_point_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_point_step_tb
// Self-checking bench for the orbit point step: directed corner positions,
// then random transactions across several step distances and idle patterns,
// each result checked against a behavioral prediction in issue order.
// ----------------------------------------------------------------------------
module orbit_point_step_tb;
    import ops_pkg::*;

    localparam int CB      = 15;
    localparam int LATENCY = 101;
    localparam logic signed [CB-1:0] CMAX = CB'((1 <<< (CB-1)) - 1);
    localparam logic signed [CB-1:0] CMIN = CB'(-(1 <<< (CB-1)));

    typedef struct packed {
        logic signed [OUT_BITS-1:0] nx;
        logic signed [OUT_BITS-1:0] ny;
        logic signed [CB-1:0]       nz;
        logic                       ok;
    } t_waypoint;

    // Prediction and ordered comparison of waypoints.
    class waypoint_board;
        t_waypoint pending[$];
        int        errors;
        int        checked;
        t_step     step;

        function void set_step(t_step s);
            step = s;
        endfunction

        // Floor square root, bit by bit.
        function automatic longint unsigned root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function automatic logic signed [OUT_BITS-1:0] clamp(longint v);
            longint hi;
            hi = (longint'(1) <<< (OUT_BITS-1)) - 1;
            if (v > hi) v = hi;
            if (v < -hi - 1) v = -hi - 1;
            return v[OUT_BITS-1:0];
        endfunction

        function void note_position(logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                                    logic signed [CB-1:0] sz, logic signed [CB-1:0] cx,
                                    logic signed [CB-1:0] cy);
            t_waypoint w;
            longint dx, dy, r, ox, oy, px, py, n, d;
            w = '0;
            w.nz = sz;
            d = longint'(step);
            dx = longint'(sx) - longint'(cx);
            dy = longint'(sy) - longint'(cy);
            r = longint'(root_floor(dx*dx + dy*dy));
            if (r != 0) begin
                // SV division truncates toward zero, as needed
                ox = (-dy * d) / r;
                oy = (dx * d) / r;
                px = dx + ox;
                py = dy + oy;
                n = longint'(root_floor(px*px + py*py));
                if (n != 0) begin
                    w.nx = clamp(longint'(cx) + (px * r) / n);
                    w.ny = clamp(longint'(cy) + (py * r) / n);
                    w.ok = 1'b1;
                end
            end
            pending.push_back(w);
        endfunction

        function void check_waypoint(t_waypoint got);
            t_waypoint w;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result exp=none act=%p", $time, got);
                return;
            end
            w = pending.pop_front();
            checked++;
            if (got.nx !== w.nx) begin
                errors++;
                $display("%0t: next_x exp=%0d act=%0d", $time, w.nx, got.nx);
            end
            if (got.ny !== w.ny) begin
                errors++;
                $display("%0t: next_y exp=%0d act=%0d", $time, w.ny, got.ny);
            end
            if (got.nz !== w.nz) begin
                errors++;
                $display("%0t: next_z exp=%0d act=%0d", $time, w.nz, got.nz);
            end
            if (got.ok !== w.ok) begin
                errors++;
                $display("%0t: point_valid exp=%0b act=%0b", $time, w.ok, got.ok);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic signed [CB-1:0]  i_self_x = '0, i_self_y = '0, i_self_z = '0;
    logic signed [CB-1:0]  i_centre_x = '0, i_centre_y = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_step                 i_cfg_data = '0;
    logic                  o_strobe;
    logic signed [OUT_BITS-1:0] o_next_x, o_next_y;
    logic signed [CB-1:0]  o_next_z;
    logic                  o_point_valid;

    waypoint_board board;
    int                    send_idle_pct;
    int                    sent;

    always #5 i_clk = ~i_clk;

    orbit_point_step #(.COORD_BITS(CB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_self_x(i_self_x), .i_self_y(i_self_y), .i_self_z(i_self_z),
        .i_centre_x(i_centre_x), .i_centre_y(i_centre_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_next_x(o_next_x), .o_next_y(o_next_y),
        .o_next_z(o_next_z), .o_point_valid(o_point_valid)
    );

    // Check every strobed result at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_waypoint({o_next_x, o_next_y, o_next_z, o_point_valid});
    end

    // Present one transaction; hold it until taken, with random idle first.
    task automatic send_position(logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                                 logic signed [CB-1:0] sz, logic signed [CB-1:0] cx,
                                 logic signed [CB-1:0] cy);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_self_x <= sx; i_self_y <= sy; i_self_z <= sz;
        i_centre_x <= cx; i_centre_y <= cy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_position(sx, sy, sz, cx, cy);
        sent++;
        @(negedge i_clk);
    endtask

    // Drop start, drain the pipeline, then write the step distance.
    task automatic write_step(t_step s);
        start <= 1'b0;
        @(negedge i_clk);
        while (board.pending.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= s;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_step(s);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [CB-1:0] rand_coord();
        return CB'($urandom);
    endfunction

    // Mostly modest orbits around a random centre, with some full-range noise.
    task automatic send_random(int count);
        logic signed [CB-1:0] cx, cy, sx, sy;
        int span;
        repeat (count) begin
            cx = rand_coord();
            cy = rand_coord();
            case ($urandom_range(3))
                0: begin
                    sx = rand_coord();
                    sy = rand_coord();
                end
                1: begin
                    sx = cx + CB'($urandom_range(8)) - CB'(4);
                    sy = cy + CB'($urandom_range(8)) - CB'(4);
                end
                default: begin
                    span = 1 << $urandom_range(12);
                    sx = cx + CB'($urandom_range(2*span)) - CB'(span);
                    sy = cy + CB'($urandom_range(2*span)) - CB'(span);
                end
            endcase
            send_position(sx, sy, rand_coord(), cx, cy);
        end
    endtask

    initial begin
        board = new();
        board.set_step(STEP_RESET);
        send_idle_pct = 0;
        sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset and written steps, corners, zero radius.
        send_position('0, '0, CMAX, '0, '0);
        send_position(CMAX, CMAX, CMIN, CMIN, CMIN);
        send_position(CMIN, CMIN, '0, CMAX, CMAX);
        send_position(CMAX, CMIN, 15'sd1, CMIN, CMAX);
        send_position(15'sd1, '0, -15'sd1, '0, '0);
        send_position('0, -15'sd3, 15'sd7, '0, '0);
        send_position(15'sd100, 15'sd100, 15'sd5, 15'sd100, 15'sd100);
        send_position(-15'sd2000, 15'sd1500, '0, 15'sd300, -15'sd700);
        write_step('0);
        send_position(15'sd1000, '0, '0, '0, '0);
        send_position(CMIN, CMAX, CMAX, CMAX, CMIN);
        write_step('1);
        send_position(15'sd1, '0, '0, '0, '0);
        send_position(CMAX, '0, CMIN, CMIN, '0);
        send_position('0, '0, '0, '0, '0);
        send_position(-15'sd1, -15'sd1, '0, '0, '0);
        write_step(t_step'(1));
        // unit step on the smallest radii
        send_position(15'sd1, '0, '0, '0, '0);
        send_position(15'sd1, 15'sd1, '0, '0, '0);

        // Random phases: sender idles lightly, then heavily, then never.
        send_idle_pct = 12;
        write_step(STEP_RESET);
        send_random(110);
        send_idle_pct = 71;
        write_step(t_step'($urandom_range(4095)));
        send_random(110);
        send_idle_pct = 0;
        write_step('1);
        send_random(110);
        write_step(t_step'($urandom_range(64)));
        send_random(110);

        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Covered %0d transactions, %0d results checked, reset and written steps.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("orbit_point_step_tb passed");
        else
            $display("orbit_point_step_tb failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("orbit_point_step_tb failed");
        $finish;
    end
endmodule

// File: orbit_point_step.f
hdl/ops_pkg.sv
hdl/ops_sqrt_cell.sv
hdl/ops_div_cell.sv
hdl/orbit_point_step.sv
tb/orbit_point_step_tb.sv
